[design/vpf_pkg.sv]
// Package with widths, codes and calibration coefficients of the Venturi flow filter.
package vpf_pkg;

   localparam int PRESSURE_W  = 24;
   localparam int FLOW_W      = 32;
   localparam int SUM_W       = 48;
   localparam int WEIGHT_W    = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;
   localparam int ACC_W       = 41;
   localparam int PROD_W      = 64;
   localparam int RAW_W       = 33;

   // Item operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SENSOR_MODEL     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SMOOTHING_WEIGHT = 1'd1;

   // Sensor models
   localparam logic MODEL_CUBIC   = 1'b0;
   localparam logic MODEL_QUARTIC = 1'b1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd52429;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

   // Coefficients in signed Q.24, leading coefficient first.
   localparam logic signed [ACC_W-1:0] CUBIC_C0   = 41'sd2538393;
   localparam logic signed [ACC_W-1:0] CUBIC_C1   = -41'sd56076167;
   localparam logic signed [ACC_W-1:0] CUBIC_C2   = 41'sd698888487;
   localparam logic signed [ACC_W-1:0] QUARTIC_C0 = -41'sd1085704;
   localparam logic signed [ACC_W-1:0] QUARTIC_C1 = 41'sd24295706;
   localparam logic signed [ACC_W-1:0] QUARTIC_C2 = -41'sd188824618;
   localparam logic signed [ACC_W-1:0] QUARTIC_C3 = 41'sd731528717;

   // Index of the last coefficient of each curve.
   localparam logic [1:0] CUBIC_LAST   = 2'd2;
   localparam logic [1:0] QUARTIC_LAST = 2'd3;

   function automatic logic signed [ACC_W-1:0] coef(input logic model, input logic [1:0] idx);
      logic signed [ACC_W-1:0] c;
      c = '0;
      if (model == MODEL_QUARTIC) begin
         case (idx)
            2'd0:    c = QUARTIC_C0;
            2'd1:    c = QUARTIC_C1;
            2'd2:    c = QUARTIC_C2;
            default: c = QUARTIC_C3;
         endcase
      end else begin
         case (idx)
            2'd0:    c = CUBIC_C0;
            2'd1:    c = CUBIC_C1;
            default: c = CUBIC_C2;
         endcase
      end
      return c;
   endfunction

endpackage

[design/vpf_channels.sv]
// Valid/ready channel interfaces for pressure items, flow results and register writes.
interface vpf_req_if
   import vpf_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [PRESSURE_W-1:0] pressure;

   modport source (output valid, output op, output pressure, input ready);
   modport sink   (input valid, input op, input pressure, output ready);
endinterface

interface vpf_rsp_if
   import vpf_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [FLOW_W-1:0] filtered_flow;
   logic signed [SUM_W-1:0]  flow_integral;

   modport source (output valid, output filtered_flow, output flow_integral, input ready);
   modport sink   (input valid, input filtered_flow, input flow_integral, output ready);
endinterface

interface vpf_csr_if
   import vpf_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/venturi_pressure_to_flow_filter_unit.sv]
// Venturi pressure-to-flow filter: Horner calibration and smoothing on one shared multiplier.
// A sample item runs the Horner steps of the cubic or quartic curve, then the smoothing;
// a clear item zeroes the integral and goes straight to the result. One item at a time:
// a new item is taken only after the last one has left the done state. A sample item
// makes two passes through the single 33x25 multiplier per multiplication by the
// magnitude and two for the smoothing. Synchronous reset clears the filter state, the
// integral and the output valid flag, and restores the cubic curve and a weight of 52429.
module venturi_pressure_to_flow_filter_unit
   import vpf_pkg::*;
   (
   input  logic       clock,
   input  logic       reset,
   vpf_req_if.sink    req_chan,
   vpf_rsp_if.source  rsp_chan,
   vpf_csr_if.sink    csr_chan
   );

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_HORNER, ST_FINAL,
      ST_SMOOTH_A, ST_SMOOTH_B, ST_SMOOTH_C, ST_DONE
   } state_type;

   localparam logic signed [PROD_W-1:0] ACC_MAX = 64'sd549755813888;
   localparam logic signed [PROD_W-1:0] ACC_MIN = -64'sd549755813888;
   localparam logic signed [PROD_W-1:0] FLOW_MAX = 64'sd2147483647;
   localparam logic signed [PROD_W-1:0] FLOW_MIN = -64'sd2147483648;
   localparam logic signed [SUM_W:0]    SUM_MAX = 49'sd140737488355327;
   localparam logic signed [SUM_W:0]    SUM_MIN = -49'sd140737488355328;

   state_type                  state_ff, state_in;
   logic                       model_ff;
   logic [WEIGHT_W-1:0]        weight_ff;
   logic signed [FLOW_W-1:0]   smoothed_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [PRESSURE_W-1:0]      mag_ff;
   logic                       neg_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [2:0]                 step_ff;
   logic signed [RAW_W-1:0]    raw_ff, raw_in;
   logic                       rsp_valid_ff;
   logic signed [FLOW_W-1:0]   rsp_flow_ff;
   logic signed [SUM_W-1:0]    rsp_sum_ff;

   logic signed [32:0]         mul_a;
   logic signed [24:0]         mul_b;
   logic signed [57:0]         mul_p;
   logic [WEIGHT_W-1:0]        w_eff;
   logic [WEIGHT_W-1:0]        w_rest;
   logic [1:0]                 last_idx;
   logic signed [PROD_W-1:0]   rnd16, rnd24, horner_sum;
   logic signed [FLOW_W-1:0]   flow_clamped, smooth_clamped;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [SUM_W-1:0]    sum_in;
   logic [PRESSURE_W-1:0]      req_mag;
   logic                       req_accept;
   logic                       out_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.filtered_flow = rsp_flow_ff;
   assign rsp_chan.flow_integral = rsp_sum_ff;

   assign w_eff    = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;
   assign w_rest   = WEIGHT_ONE - w_eff;
   assign last_idx = (model_ff == MODEL_QUARTIC) ? QUARTIC_LAST : CUBIC_LAST;
   assign req_mag  = req_chan.pressure[PRESSURE_W-1] ?
                     (~req_chan.pressure + 24'd1) : req_chan.pressure;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = {9'b0, mag_ff};
      mul_b = {1'b0, acc_ff[23:0]};
      case (state_ff)
         ST_MUL_HI: begin
            mul_b = {{8{acc_ff[ACC_W-1]}}, acc_ff[ACC_W-1:24]};
         end
         ST_SMOOTH_A: begin
            mul_a = 33'(smoothed_ff);
            mul_b = {8'b0, w_eff};
         end
         ST_SMOOTH_B: begin
            mul_a = raw_ff;
            mul_b = {8'b0, w_rest};
         end
         default: begin
            mul_a = {9'b0, mag_ff};
            mul_b = {1'b0, acc_ff[23:0]};
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Rounding half away from zero is an arithmetic shift of v + half - sign.
   always_comb begin
      rnd16 = (prod_ff + 64'sd32768 - (prod_ff[PROD_W-1] ? 64'sd1 : 64'sd0)) >>> 16;
      rnd24 = (prod_ff + 64'sd8388608 - (prod_ff[PROD_W-1] ? 64'sd1 : 64'sd0)) >>> 24;
      horner_sum = rnd16 + PROD_W'(coef(model_ff, step_ff[1:0]));
      if (horner_sum > ACC_MAX) begin
         acc_in = ACC_MAX[ACC_W-1:0];
      end else if (horner_sum < ACC_MIN) begin
         acc_in = ACC_MIN[ACC_W-1:0];
      end else begin
         acc_in = horner_sum[ACC_W-1:0];
      end
      if (rnd24 > FLOW_MAX) begin
         flow_clamped = FLOW_MAX[FLOW_W-1:0];
      end else if (rnd24 < FLOW_MIN) begin
         flow_clamped = FLOW_MIN[FLOW_W-1:0];
      end else begin
         flow_clamped = rnd24[FLOW_W-1:0];
      end
      raw_in = neg_ff ? -RAW_W'(flow_clamped) : RAW_W'(flow_clamped);
      if (rnd16 > FLOW_MAX) begin
         smooth_clamped = FLOW_MAX[FLOW_W-1:0];
      end else if (rnd16 < FLOW_MIN) begin
         smooth_clamped = FLOW_MIN[FLOW_W-1:0];
      end else begin
         smooth_clamped = rnd16[FLOW_W-1:0];
      end
      sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(raw_ff);
      if (sum_wide > SUM_MAX) begin
         sum_in = SUM_MAX[SUM_W-1:0];
      end else if (sum_wide < SUM_MIN) begin
         sum_in = SUM_MIN[SUM_W-1:0];
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_chan.op == OP_CLEAR) ? ST_DONE : ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            prod_in  = PROD_W'(mul_p);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_in  = prod_ff + (PROD_W'(mul_p) <<< 24);
            state_in = (step_ff <= {1'b0, last_idx}) ? ST_HORNER : ST_FINAL;
         end
         ST_HORNER: begin
            state_in = ST_MUL_LO;
         end
         ST_FINAL: begin
            state_in = ST_SMOOTH_A;
         end
         ST_SMOOTH_A: begin
            prod_in  = PROD_W'(mul_p);
            state_in = ST_SMOOTH_B;
         end
         ST_SMOOTH_B: begin
            prod_in  = prod_ff + PROD_W'(mul_p);
            state_in = ST_SMOOTH_C;
         end
         ST_SMOOTH_C: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         model_ff     <= MODEL_CUBIC;
         weight_ff    <= WEIGHT_RESET;
         smoothed_ff  <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               REG_SENSOR_MODEL:     model_ff  <= csr_chan.data[0];
               REG_SMOOTHING_WEIGHT: weight_ff <= csr_chan.data[WEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  mag_ff  <= req_mag;
                  neg_ff  <= req_chan.pressure[PRESSURE_W-1];
                  acc_ff  <= coef(model_ff, 2'd0);
                  step_ff <= 3'd1;
                  if (req_chan.op == OP_CLEAR) begin
                     sum_ff <= '0;
                  end
               end
            end
            ST_HORNER: begin
               acc_ff  <= acc_in;
               step_ff <= step_ff + 3'd1;
            end
            ST_FINAL: begin
               raw_ff <= raw_in;
            end
            ST_SMOOTH_A: begin
               sum_ff <= sum_in;
            end
            ST_SMOOTH_C: begin
               smoothed_ff <= smooth_clamped;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_flow_ff  <= smoothed_ff;
                  rsp_sum_ff   <= sum_ff;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
